// ===== rtl/preemptive_priority_scheduler_core_defines.svh =====
// assertion macros for the preemptive priority scheduler core
// used only by the top level, no other dependencies
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_CORE_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PPSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PPSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ppsc_pkg.sv =====
// shared constants and types for the preemptive priority scheduler
// no dependencies
package ppsc_pkg;

    // fixed field widths of the stream payload
    localparam int SLOT_W    = 4;
    localparam int LABEL_W   = 8;
    localparam int ARRIVAL_W = 16;
    localparam int WORK_W    = 16;
    localparam int URG_W     = 8;
    localparam int CFG_W     = 5;
    localparam int OUT_TIME_W = 16;

    // operation codes carried on the input tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // control from the sequencer to the selection datapath
    typedef struct packed {
        logic clear;  // start of a tick, drop previous best
        logic eval;   // read data of one entry is present
    } t_sel_ctrl;

endpackage

// ===== rtl/ppsc_task_mem.sv =====
// task table storage: static fields memory, remaining-time memory, valid bits
// depends on ppsc_pkg
module ppsc_task_mem import ppsc_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4,
    parameter int ARR_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ld_we,
    input  logic [IDX_W-1:0]   i_ld_addr,
    input  logic [LABEL_W-1:0] i_label,
    input  logic [ARR_W-1:0]   i_arrival,
    input  logic [URG_W-1:0]   i_urgency,
    input  logic               i_rem_we,
    input  logic [IDX_W-1:0]   i_rem_addr,
    input  logic [WORK_W-1:0]  i_rem_data,
    input  logic [IDX_W-1:0]   i_rd_addr,
    output logic [LABEL_W-1:0] o_label,
    output logic [ARR_W-1:0]   o_arrival,
    output logic [URG_W-1:0]   o_urgency,
    output logic [WORK_W-1:0]  o_rem
);

    localparam int STAT_W = LABEL_W + ARR_W + URG_W;

    logic [STAT_W-1:0] mem_stat [DEPTH];
    logic [WORK_W-1:0] mem_rem  [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [STAT_W-1:0] r_stat_q;
    logic [WORK_W-1:0] r_rem_q;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ld_we) begin
            mem_stat[i_ld_addr] <= {i_label, i_arrival, i_urgency};
        end
        r_stat_q <= mem_stat[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_rem_we) begin
            mem_rem[i_rem_addr] <= i_rem_data;
        end
        r_rem_q <= mem_rem[i_rd_addr];
    end

    // never-loaded entries read as zero remaining time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ld_we) begin
                r_valid[i_ld_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_label   = r_stat_q[STAT_W-1 -: LABEL_W];
    assign o_arrival = r_stat_q[URG_W +: ARR_W];
    assign o_urgency = r_stat_q[URG_W-1:0];
    assign o_rem     = r_rd_valid ? r_rem_q : '0;

endmodule

// ===== rtl/ppsc_select.sv =====
// best-candidate tracking over one scan of the task table
// depends on ppsc_pkg
module ppsc_select import ppsc_pkg::*; #(
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5,
    parameter int ARR_W     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_sel_ctrl            i_ctrl,
    input  logic [TIME_BITS-1:0] i_start,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic [LABEL_W-1:0]   i_label,
    input  logic [ARR_W-1:0]     i_arrival,
    input  logic [URG_W-1:0]     i_urgency,
    input  logic [WORK_W-1:0]    i_rem,
    output logic                 o_found,
    output logic [IDX_W-1:0]     o_best_idx,
    output logic [LABEL_W-1:0]   o_best_label,
    output logic [WORK_W-1:0]    o_best_rem,
    output logic [CNT_W-1:0]     o_busy_cnt
);

    logic                r_found;
    logic [CNT_W-1:0]    r_busy_cnt;
    logic [IDX_W-1:0]    r_best_idx;
    logic [LABEL_W-1:0]  r_best_label;
    logic [WORK_W-1:0]   r_best_rem;
    logic [URG_W-1:0]    r_best_urg;
    logic                rem_nz;
    logic                cand;
    logic                take;

    assign rem_nz = (i_rem != '0);
    assign cand   = rem_nz && (TIME_BITS'(i_arrival) <= i_start);
    // strict compare keeps the lowest index on a tie
    assign take   = i_ctrl.eval && cand && (!r_found || (i_urgency > r_best_urg));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found    <= 1'b0;
            r_busy_cnt <= '0;
        end else if (i_ctrl.clear) begin
            r_found    <= 1'b0;
            r_busy_cnt <= '0;
        end else if (i_ctrl.eval) begin
            if (take) begin
                r_found <= 1'b1;
            end
            if (rem_nz) begin
                r_busy_cnt <= r_busy_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_idx   <= i_idx;
            r_best_label <= i_label;
            r_best_rem   <= i_rem;
            r_best_urg   <= i_urgency;
        end
    end

    assign o_found      = r_found;
    assign o_best_idx   = r_best_idx;
    assign o_best_label = r_best_label;
    assign o_best_rem   = r_best_rem;
    assign o_busy_cnt   = r_busy_cnt;

endmodule

// ===== rtl/preemptive_priority_scheduler_core.sv =====
// a tick scans min(entry_count, TABLE_DEPTH) table entries, then commits its result once the
// output is free; a waiting result holds the sequencer in finish until the output takes it
// a tick blocks the input until its result is committed; loads are taken while idle
// the scan reads one table entry per cycle through the one read port of the task memories
// reset: synchronous active low; clears valid bits (remaining time reads zero),
// time, entry_count, the sequencer and the output valid; no clearing pass
module preemptive_priority_scheduler_core import ppsc_pkg::*; #(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: entry_count
    input  logic        i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slot[3:0], label[11:4], arrival[27:12], work_left[43:28], urgency[51:44]
    input  logic [55:0] s_axis_tdata,
    // operation[0]
    input  logic        s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // winner_index[3:0], winner_label[11:4], tick_time[27:12],
    // task_finished[28], all_done[29]
    output logic [31:0] m_axis_tdata,
    // ran[0]
    output logic        m_axis_tuser
);

`include "preemptive_priority_scheduler_core_defines.svh"

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ARR_W = (TIME_BITS < ARRIVAL_W) ? TIME_BITS : ARRIVAL_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // input field unpacking
    logic [SLOT_W-1:0]    in_slot;
    logic [LABEL_W-1:0]   in_label;
    logic [ARRIVAL_W-1:0] in_arrival;
    logic [WORK_W-1:0]    in_work;
    logic [URG_W-1:0]     in_urg;

    assign in_slot    = s_axis_tdata[3:0];
    assign in_label   = s_axis_tdata[11:4];
    assign in_arrival = s_axis_tdata[27:12];
    assign in_work    = s_axis_tdata[43:28];
    assign in_urg     = s_axis_tdata[51:44];

    // control and state registers
    logic [1:0]           r_state, n_state;
    logic [CFG_W-1:0]     r_entry_count;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [TIME_BITS-1:0] r_start;
    logic [CNT_W-1:0]     r_limit;
    logic [CNT_W-1:0]     r_issue, n_issue;
    logic                 r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;

    // output register
    logic                  r_m_tvalid;
    logic                  r_out_ran;
    logic [SLOT_W-1:0]     r_out_idx;
    logic [LABEL_W-1:0]    r_out_label;
    logic [OUT_TIME_W-1:0] r_out_time;
    logic                  r_out_fin;
    logic                  r_out_done;

    logic             in_xfer;
    logic             load_xfer;
    logic             tick_xfer;
    logic             slot_ok;
    logic [CNT_W-1:0] limit;
    logic             issue_act;
    logic             out_free;
    logic             commit;

    // datapath wiring
    t_sel_ctrl          sel_ctrl;
    logic [LABEL_W-1:0] mem_label;
    logic [ARR_W-1:0]   mem_arrival;
    logic [URG_W-1:0]   mem_urg;
    logic [WORK_W-1:0]  mem_rem;
    logic               sel_found;
    logic [IDX_W-1:0]   sel_idx;
    logic [LABEL_W-1:0] sel_label;
    logic [WORK_W-1:0]  sel_rem;
    logic [CNT_W-1:0]   sel_busy;
    logic               finished;
    logic               all_done;
    logic               rem_we;
    logic [IDX_W-1:0]   rem_addr;
    logic [WORK_W-1:0]  rem_data;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    // a load to a slot beyond the table is dropped
    assign slot_ok       = (32'(in_slot) < TABLE_DEPTH);
    assign load_xfer     = in_xfer && (s_axis_tuser == OP_LOAD);
    assign tick_xfer     = in_xfer && (s_axis_tuser == OP_TICK);

    // entry_count above the table depth acts as the depth
    always_comb begin
        if (32'(r_entry_count) > TABLE_DEPTH) begin
            limit = CNT_W'(TABLE_DEPTH);
        end else begin
            limit = CNT_W'(r_entry_count);
        end
    end

    assign issue_act = (r_state == ST_SCAN) && (r_issue < r_limit);
    assign out_free  = !r_m_tvalid || m_axis_tready;
    assign commit    = (r_state == ST_FINISH) && out_free;

    // chosen entry ends when its last unit is taken
    assign finished = sel_found && (sel_rem == WORK_W'(1));
    // busy entries left after this tick: all busy ones minus the one that finished
    assign all_done = (sel_busy == CNT_W'(finished));

    // remaining-time write port: loads, and the decrement at commit
    always_comb begin
        if (load_xfer) begin
            rem_we   = slot_ok;
            rem_addr = IDX_W'(in_slot);
            rem_data = in_work;
        end else begin
            rem_we   = commit && sel_found;
            rem_addr = sel_idx;
            rem_data = sel_rem - 1'b1;
        end
    end

    assign sel_ctrl.clear = tick_xfer;
    assign sel_ctrl.eval  = r_rd_vld;

    ppsc_task_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W),
        .ARR_W (ARR_W)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ld_we    (load_xfer && slot_ok),
        .i_ld_addr  (IDX_W'(in_slot)),
        .i_label    (in_label),
        .i_arrival  (ARR_W'(in_arrival)),
        .i_urgency  (in_urg),
        .i_rem_we   (rem_we),
        .i_rem_addr (rem_addr),
        .i_rem_data (rem_data),
        .i_rd_addr  (r_issue[IDX_W-1:0]),
        .o_label    (mem_label),
        .o_arrival  (mem_arrival),
        .o_urgency  (mem_urg),
        .o_rem      (mem_rem)
    );

    ppsc_select #(
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W),
        .ARR_W     (ARR_W),
        .TIME_BITS (TIME_BITS)
    ) u_sel (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (sel_ctrl),
        .i_start      (r_start),
        .i_idx        (r_rd_idx),
        .i_label      (mem_label),
        .i_arrival    (mem_arrival),
        .i_urgency    (mem_urg),
        .i_rem        (mem_rem),
        .o_found      (sel_found),
        .o_best_idx   (sel_idx),
        .o_best_label (sel_label),
        .o_best_rem   (sel_rem),
        .o_busy_cnt   (sel_busy)
    );

    // sequencer: idle -> scan one entry per cycle -> finish when output is free
    always_comb begin
        n_state  = r_state;
        n_issue  = r_issue;
        n_rd_vld = 1'b0;
        n_now    = r_now;
        unique case (r_state)
            ST_IDLE: begin
                if (tick_xfer) begin
                    n_state = ST_SCAN;
                    n_issue = '0;
                end
            end
            ST_SCAN: begin
                if (issue_act) begin
                    n_issue  = r_issue + 1'b1;
                    n_rd_vld = 1'b1;
                end else if (!r_rd_vld) begin
                    // last read evaluated, pipeline empty
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                    // time saturates at its maximum
                    if (r_now != '1) begin
                        n_now = r_now + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_entry_count <= '0;
            r_now         <= '0;
            r_issue       <= '0;
            r_rd_vld      <= 1'b0;
            r_limit       <= '0;
            r_m_tvalid    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issue  <= n_issue;
            r_rd_vld <= n_rd_vld;
            r_now    <= n_now;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
            if (tick_xfer) begin
                r_limit <= limit;
            end
            if (commit) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (tick_xfer) begin
            r_start <= r_now;
        end
        r_rd_idx <= r_issue[IDX_W-1:0];
        if (commit) begin
            r_out_ran   <= sel_found;
            r_out_idx   <= sel_found ? SLOT_W'(sel_idx) : '0;
            r_out_label <= sel_found ? sel_label : '0;
            r_out_time  <= OUT_TIME_W'(r_start);
            r_out_fin   <= finished;
            r_out_done  <= all_done;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tuser  = r_out_ran;
    assign m_axis_tdata  = {2'b00, r_out_done, r_out_fin, r_out_time, r_out_label, r_out_idx};

    // a chosen entry always had time left when it was picked
    `PPSC_ASSERT_NOW(a_pick_has_work, i_clk, i_rst_n, (r_state == ST_FINISH) && sel_found, sel_rem != '0, "picked entry with zero remaining time")
    // the scan never reads past the clamped entry count
    `PPSC_ASSERT_NOW(a_scan_bound, i_clk, i_rst_n, r_state == ST_SCAN, r_issue <= r_limit, "scan index beyond entry limit")
    // a tick transfer always starts a scan
    `PPSC_ASSERT_NEXT(a_tick_scans, i_clk, i_rst_n, tick_xfer, r_state == ST_SCAN, "tick transfer did not start a scan")
    // the busy count can never exceed the entries scanned
    `PPSC_ASSERT_NOW(a_busy_bound, i_clk, i_rst_n, r_state == ST_FINISH, sel_busy <= r_limit, "busy count above scanned entries")

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the preemptive priority scheduler core
// sends load and tick transfers, predicts every slot report and compares it field by field
// depends on ppsc_pkg and preemptive_priority_scheduler_core
module tb_top;
    import ppsc_pkg::*;

    localparam int          DEPTH        = 16;
    localparam int          DRAIN_CYCLES = 32;       // settle time after everything is drained
    localparam int          RUN_ITEMS    = 325;      // per random phase
    localparam logic [15:0] TIME_TOP     = 16'hffff;

    typedef struct {
        logic        op;
        logic [3:0]  slot;
        logic [7:0]  label;
        logic [15:0] arrival;
        logic [15:0] work;
        logic [7:0]  urgency;
    } sched_item_t;

    typedef struct {
        logic        ran;
        logic [3:0]  index;
        logic [7:0]  label;
        logic [15:0] start;
        logic        finished;
        logic        all_done;
    } slot_report_t;

    // block ports, all inputs known from time zero
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata   = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // slot, label, arrival, work_left, urgency from bit 0 up
    logic [55:0]      s_axis_tdata  = '0;
    // operation
    logic             s_axis_tuser  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // winner_index, winner_label, tick_time, task_finished, all_done from bit 0 up
    logic [31:0]      m_axis_tdata;
    // ran
    logic             m_axis_tuser;

    // predictor copy of the task table, time and entry count
    logic [7:0]       tbl_label     [DEPTH];
    logic [15:0]      tbl_arrival   [DEPTH];
    logic [15:0]      tbl_remaining [DEPTH];
    logic [7:0]       tbl_urgency   [DEPTH];
    logic [15:0]      sched_now;
    logic [CFG_W-1:0] sched_count;

    sched_item_t  pending_q[$];      // items waiting for the driver
    slot_report_t slot_report_q[$];  // predicted reports, oldest first
    sched_item_t  offer;
    logic         offer_live = 1'b0; // an item sits on the input, not yet taken

    int gen_now     = 0;             // time the generator expects once its ticks are done
    int mismatches  = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic recv_hold = 1'b0;

    preemptive_priority_scheduler_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [15:0] time_step(input logic [15:0] t);
        return (t == TIME_TOP) ? t : t + 16'd1;
    endfunction

    // a load fills one table entry; a tick runs one slot of the schedule
    task automatic schedule_transfer(input sched_item_t it);
        slot_report_t rep;
        int           lim;
        int           i;
        int           pick;
        logic         found;
        logic         busy;
        logic [7:0]   best;
        if (it.op == OP_LOAD) begin
            tbl_label[it.slot]     = it.label;
            tbl_arrival[it.slot]   = it.arrival;
            tbl_remaining[it.slot] = it.work;
            tbl_urgency[it.slot]   = it.urgency;
        end else begin
            // a count above the table depth acts as the full table
            lim   = (sched_count > DEPTH) ? DEPTH : sched_count;
            found = 1'b0;
            busy  = 1'b0;
            pick  = 0;
            best  = '0;
            // strictly larger urgency wins, so ties stay with the lowest index
            for (i = 0; i < lim; i++) begin
                if (tbl_remaining[i] != 0 && tbl_arrival[i] <= sched_now) begin
                    if (!found || tbl_urgency[i] > best) begin
                        found = 1'b1;
                        best  = tbl_urgency[i];
                        pick  = i;
                    end
                end
            end
            rep.start    = sched_now;
            rep.ran      = found;
            rep.index    = found ? pick[3:0] : 4'd0;
            rep.label    = found ? tbl_label[pick] : 8'd0;
            rep.finished = 1'b0;
            if (found) begin
                tbl_remaining[pick] = tbl_remaining[pick] - 16'd1;
                rep.finished        = (tbl_remaining[pick] == 0);
            end
            // time advances on idle slots too, and stops at its maximum
            sched_now = time_step(sched_now);
            for (i = 0; i < lim; i++) begin
                if (tbl_remaining[i] != 0) begin
                    busy = 1'b1;
                end
            end
            rep.all_done = !busy;
            slot_report_q.push_back(rep);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
        end
    endtask

    task automatic check_slot_report();
        slot_report_t want;
        if (slot_report_q.size() == 0) begin
            report_mismatch("slot report with none pending", m_axis_tdata, 0);
        end else begin
            want = slot_report_q.pop_front();
            if (m_axis_tuser !== want.ran)
                report_mismatch("ran", m_axis_tuser, want.ran);
            if (m_axis_tdata[3:0] !== want.index)
                report_mismatch("winner_index", m_axis_tdata[3:0], want.index);
            if (m_axis_tdata[11:4] !== want.label)
                report_mismatch("winner_label", m_axis_tdata[11:4], want.label);
            if (m_axis_tdata[27:12] !== want.start)
                report_mismatch("tick_time", m_axis_tdata[27:12], want.start);
            if (m_axis_tdata[28] !== want.finished)
                report_mismatch("task_finished", m_axis_tdata[28], want.finished);
            if (m_axis_tdata[29] !== want.all_done)
                report_mismatch("all_done", m_axis_tdata[29], want.all_done);
        end
    endtask

    // driver: predicts on each accepted transfer, then offers the next item or idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                schedule_transfer(offer);
                offer_live = 1'b0;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offer = pending_q.pop_front();
                    offer_live = 1'b1;
                    s_axis_tdata  <= {4'b0, offer.urgency, offer.work, offer.arrival,
                                      offer.label, offer.slot};
                    s_axis_tuser  <= offer.op;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each report transfer, stalls at random or during a hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_slot_report();
            end
            m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_load(input logic [3:0] slot, input logic [7:0] lab,
                              input logic [15:0] arr, input logic [15:0] work,
                              input logic [7:0] urg);
        sched_item_t it;
        it.op      = OP_LOAD;
        it.slot    = slot;
        it.label   = lab;
        it.arrival = arr;
        it.work    = work;
        it.urgency = urg;
        pending_q.push_back(it);
    endtask

    task automatic queue_tick();
        sched_item_t it;
        it.op      = OP_TICK;
        it.slot    = 4'($urandom_range(15));
        it.label   = 8'($urandom_range(255));
        it.arrival = 16'($urandom_range(65535));
        it.work    = 16'($urandom_range(65535));
        it.urgency = 8'($urandom_range(255));
        pending_q.push_back(it);
        if (gen_now < 65535) begin
            gen_now++;
        end
    endtask

    // everything sent, every report back, and the block given time to settle
    task automatic wait_drained();
        while (pending_q.size() != 0 || offer_live || slot_report_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // the register is only written with the block idle
    task automatic write_count(input logic [CFG_W-1:0] value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        sched_count = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly ticks, mixed with loads mostly into counted slots with near arrivals and short work
    task automatic queue_random_run(input int n);
        int          k;
        int          lim;
        int          r;
        logic [3:0]  slot;
        logic [15:0] arr;
        logic [15:0] work;
        logic [7:0]  urg;
        lim = (sched_count > DEPTH) ? DEPTH : sched_count;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(99) < 70) begin
                queue_tick();
            end else begin
                if (lim > 0 && $urandom_range(99) < 85)
                    slot = 4'($urandom_range(lim - 1));
                else
                    slot = 4'($urandom_range(15));
                r = $urandom_range(99);
                if (r < 70)
                    arr = (gen_now + 23 > 65535) ? TIME_TOP
                                                 : 16'(gen_now + $urandom_range(23));
                else if (r < 80)
                    arr = 16'd0;
                else if (r < 90)
                    arr = 16'($urandom_range(65535));
                else
                    arr = TIME_TOP;
                r = $urandom_range(99);
                if (r < 85)
                    work = 16'($urandom_range(4, 1));
                else if (r < 95)
                    work = 16'd0;
                else
                    work = 16'($urandom_range(65535));
                // small urgencies make ties common
                r = $urandom_range(99);
                if (r < 50)
                    urg = 8'($urandom_range(3));
                else if (r < 60)
                    urg = 8'hff;
                else
                    urg = 8'($urandom_range(255));
                queue_load(slot, 8'($urandom_range(255)), arr, work, urg);
            end
        end
    endtask

    // hard stop for a hung handshake
    initial begin
        #24000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int               s;
        int               ph;
        int               send_mode  [4] = '{0, 86, 0, 7};
        int               stall_mode [4] = '{0, 0, 86, 7};
        logic [CFG_W-1:0] count_mode [4] = '{5'd16, 5'd5, 5'd9, 5'd17};

        for (s = 0; s < DEPTH; s++) begin
            tbl_label[s]     = '0;
            tbl_arrival[s]   = '0;
            tbl_remaining[s] = '0;
            tbl_urgency[s]   = '0;
        end
        sched_now   = '0;
        sched_count = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty schedule: idle slots with all_done set
        write_count(5'd0);
        queue_tick();
        queue_tick();

        // fill the whole table before any counted entry is scanned
        queue_load(4'd0, 8'h00, 16'd0, 16'd3, 8'd5);
        queue_load(4'd1, 8'hff, 16'd0, 16'd1, 8'd5);          // same urgency as slot 0
        queue_load(4'd2, 8'ha5, TIME_TOP, 16'hffff, 8'hff);   // arrives only at the time limit
        queue_load(4'd3, 8'h5a, 16'd4, 16'd1, 8'd200);        // arrives later and preempts
        queue_load(4'd4, 8'h3c, 16'd0, 16'd0, 8'd0);
        for (s = 5; s < DEPTH - 1; s++) begin
            queue_load(4'(s), 8'(s * 17), 16'(s), 16'd0, 8'(s * 16));
        end
        queue_load(4'd15, 8'hc3, 16'd0, 16'd0, 8'hff);        // no work left, never picked

        // count above the table depth, tie, preemption, finish, idle with work pending
        write_count(5'd31);
        repeat (6) queue_tick();

        // the pending long task drops out of the count
        write_count(5'd2);
        queue_tick();

        for (ph = 0; ph < 4; ph++) begin
            write_count(count_mode[ph]);
            send_idle_pct  <= send_mode[ph];
            recv_stall_pct <= stall_mode[ph];
            queue_random_run(RUN_ITEMS);
            if (ph == 0) begin
                // long receiver hold-off while the sender keeps offering
                fork
                    begin
                        recv_hold <= 1'b1;
                        repeat (500) @(posedge i_clk);
                        recv_hold <= 1'b0;
                    end
                join_none
            end
        end

        // tasks that arrive only at the time limit stay idle beside leftover work
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        write_count(5'd16);
        queue_load(4'd0, 8'h81, TIME_TOP, 16'd2, 8'd9);
        queue_load(4'd1, 8'h7e, TIME_TOP, 16'd1, 8'd9);
        repeat (8) queue_tick();

        wait_drained();
        if (mismatches == 0 && slot_report_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
